[rtl/core/tcgr_pkg.sv]
package tcgr_pkg;

  // opcodes of the input word
  typedef enum logic {
    OP_PUT_CHAR   = 1'b0,
    OP_SET_CURSOR = 1'b1
  } op_t;

  // configuration register indexes
  localparam logic [1:0] REG_FG_COLOR   = 2'd0;
  localparam logic [1:0] REG_BG_COLOR   = 2'd1;
  localparam logic [1:0] REG_TEXT_SIZE  = 2'd2;
  localparam logic [1:0] REG_DISPLAY_ON = 2'd3;

  // character codes
  localparam logic [7:0] CH_NEWLINE  = 8'd10;
  localparam logic [7:0] CH_RETURN   = 8'd13;
  localparam logic [7:0] GLYPH_FIRST = 8'd32;
  localparam logic [7:0] GLYPH_LAST  = 8'd126;

  // glyph cell geometry
  localparam int GLYPH_COLS   = 6;   // five font columns plus spacing
  localparam int GLYPH_ROWS   = 7;
  localparam int SIZE_MAX     = 8;
  localparam int QDEPTH       = 2;
  localparam logic [9:0] ROW_MAX = 10'd1023;

  localparam logic [2:0] LAST_COL = 3'(GLYPH_COLS - 1);
  localparam logic [2:0] LAST_ROW = 3'(GLYPH_ROWS - 1);

  typedef struct packed {
    logic [15:0] fg_color;
    logic [15:0] bg_color;
    logic [3:0]  text_size;
    logic        display_on;
  } cfg_t;

  // one character to draw
  typedef struct packed {
    logic [9:0] x0;
    logic [9:0] y0;
    logic [3:0] size;
    logic [6:0] glyph_idx;
  } job_t;

  // font columns packed as {spacing, c4, c3, c2, c1, c0}, bit 0 of each byte is the top row
  function automatic logic [47:0] glyph_rom(input logic [6:0] idx);
    logic [47:0] g;
    case (idx)
      7'd0:  g = 48'h00_00_00_00_00_00;
      7'd1:  g = 48'h00_00_00_5F_00_00;
      7'd2:  g = 48'h00_00_07_00_07_00;
      7'd3:  g = 48'h00_14_7F_14_7F_14;
      7'd4:  g = 48'h00_12_2A_7F_2A_24;
      7'd5:  g = 48'h00_62_64_08_13_23;
      7'd6:  g = 48'h00_50_22_55_49_36;
      7'd7:  g = 48'h00_00_00_03_05_00;
      7'd8:  g = 48'h00_00_41_22_1C_00;
      7'd9:  g = 48'h00_00_1C_22_41_00;
      7'd10: g = 48'h00_14_08_3E_08_14;
      7'd11: g = 48'h00_08_08_3E_08_08;
      7'd12: g = 48'h00_00_60_A0_00_00;
      7'd13: g = 48'h00_08_08_08_08_08;
      7'd14: g = 48'h00_00_00_60_60_00;
      7'd15: g = 48'h00_02_04_08_10_20;
      7'd16: g = 48'h00_3E_45_49_51_3E;
      7'd17: g = 48'h00_00_40_7F_42_00;
      7'd18: g = 48'h00_46_49_51_61_42;
      7'd19: g = 48'h00_31_4B_45_41_21;
      7'd20: g = 48'h00_10_7F_12_14_18;
      7'd21: g = 48'h00_39_45_45_45_27;
      7'd22: g = 48'h00_30_49_49_4A_3C;
      7'd23: g = 48'h00_03_05_09_71_01;
      7'd24: g = 48'h00_36_49_49_49_36;
      7'd25: g = 48'h00_1E_29_49_49_06;
      7'd26: g = 48'h00_00_00_36_36_00;
      7'd27: g = 48'h00_00_00_36_56_00;
      7'd28: g = 48'h00_00_41_22_14_08;
      7'd29: g = 48'h00_14_14_14_14_14;
      7'd30: g = 48'h00_08_14_22_41_00;
      7'd31: g = 48'h00_06_09_51_01_02;
      7'd32: g = 48'h00_3E_51_59_49_32;
      7'd33: g = 48'h00_7C_12_11_12_7C;
      7'd34: g = 48'h00_36_49_49_49_7F;
      7'd35: g = 48'h00_22_41_41_41_3E;
      7'd36: g = 48'h00_1C_22_41_41_7F;
      7'd37: g = 48'h00_41_49_49_49_7F;
      7'd38: g = 48'h00_01_09_09_09_7F;
      7'd39: g = 48'h00_7A_49_49_41_3E;
      7'd40: g = 48'h00_7F_08_08_08_7F;
      7'd41: g = 48'h00_00_41_7F_41_00;
      7'd42: g = 48'h00_01_3F_41_40_20;
      7'd43: g = 48'h00_41_22_14_08_7F;
      7'd44: g = 48'h00_40_40_40_40_7F;
      7'd45: g = 48'h00_7F_02_0C_02_7F;
      7'd46: g = 48'h00_7F_10_08_04_7F;
      7'd47: g = 48'h00_3E_41_41_41_3E;
      7'd48: g = 48'h00_06_09_09_09_7F;
      7'd49: g = 48'h00_5E_21_51_41_3E;
      7'd50: g = 48'h00_46_29_19_09_7F;
      7'd51: g = 48'h00_31_49_49_49_46;
      7'd52: g = 48'h00_01_01_7F_01_01;
      7'd53: g = 48'h00_3F_40_40_40_3F;
      7'd54: g = 48'h00_1F_20_40_20_1F;
      7'd55: g = 48'h00_3F_40_38_40_3F;
      7'd56: g = 48'h00_63_14_08_14_63;
      7'd57: g = 48'h00_07_08_70_08_07;
      7'd58: g = 48'h00_43_45_49_51_61;
      7'd59: g = 48'h00_00_41_41_7F_00;
      7'd60: g = 48'h00_55_2A_55_2A_55;
      7'd61: g = 48'h00_00_7F_41_41_00;
      7'd62: g = 48'h00_04_02_01_02_04;
      7'd63: g = 48'h00_40_40_40_40_40;
      7'd64: g = 48'h00_00_04_02_01_00;
      7'd65: g = 48'h00_78_54_54_54_20;
      7'd66: g = 48'h00_38_44_44_48_7F;
      7'd67: g = 48'h00_20_44_44_44_38;
      7'd68: g = 48'h00_7F_48_44_44_38;
      7'd69: g = 48'h00_18_54_54_54_38;
      7'd70: g = 48'h00_02_01_09_7E_08;
      7'd71: g = 48'h00_3E_52_52_52_0C;
      7'd72: g = 48'h00_78_04_04_08_7F;
      7'd73: g = 48'h00_00_40_7D_44_00;
      7'd74: g = 48'h00_00_3D_44_40_20;
      7'd75: g = 48'h00_44_28_10_7F_00;
      7'd76: g = 48'h00_00_40_7F_41_00;
      7'd77: g = 48'h00_78_04_18_04_7C;
      7'd78: g = 48'h00_78_04_04_08_7C;
      7'd79: g = 48'h00_38_44_44_44_38;
      7'd80: g = 48'h00_08_14_14_14_7C;
      7'd81: g = 48'h00_7C_18_14_14_08;
      7'd82: g = 48'h00_08_04_04_08_7C;
      7'd83: g = 48'h00_20_54_54_54_48;
      7'd84: g = 48'h00_20_40_44_3F_04;
      7'd85: g = 48'h00_7C_20_40_40_3C;
      7'd86: g = 48'h00_1C_20_40_20_1C;
      7'd87: g = 48'h00_3C_40_30_40_3C;
      7'd88: g = 48'h00_44_28_10_28_44;
      7'd89: g = 48'h00_3C_50_50_50_0C;
      7'd90: g = 48'h00_44_4C_54_64_44;
      7'd91: g = 48'h00_00_00_41_36_08;
      7'd92: g = 48'h00_00_00_7F_00_00;
      7'd93: g = 48'h00_00_08_36_41_00;
      7'd94: g = 48'h00_08_10_08_08_10;
      default: g = 48'h00_00_00_00_00_00;
    endcase
    return g;
  endfunction

endpackage

[rtl/core/text_cursor_glyph_renderer_unit.sv]
// Text renderer with a 5x7 character generator.
// Input channel (in_valid/in_ready): one word is either a character byte to
// print or a set-cursor command. Newline, carriage return, set-cursor, dropped
// and display-off words produce nothing; every other word produces 42 output
// words on the out_valid/out_ready channel, one square block each: five font
// columns of seven rows top to bottom, then a background spacing column.
// out_last_block marks the 42nd block of a character.
// Configuration is a plain write port (cfg_wr_en, cfg_index, cfg_wdata); the
// user must write it only while the renderer is idle; this is not enforced.
// An accepted character passes the queue slot and the sequencer's job
// register before its first block enters the output word register. While the
// output is not stalled the sequencer emits one block per cycle; a queued
// character's blocks follow its predecessor's with no gap. A two-entry queue
// between the classifier and the sequencer lets up to two characters wait, so
// non-drawing words are absorbed at one per cycle while the queue has room,
// even while a glyph is emitted. When out_ready is low the output word holds
// and the sequencer pauses; input is refused only when the queue is full.
// Reset (synchronous, rst_n low) clears the cursor, the drop flag, the queue
// and the output valid, and loads the default colours, size and display off.
module text_cursor_glyph_renderer_unit
  import tcgr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 285
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_wdata,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_opcode,
  input  logic [7:0]  in_char_code,
  input  logic        in_string_start,
  input  logic [9:0]  in_cursor_x_value,
  input  logic [9:0]  in_cursor_y_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_block_x,
  output logic [8:0]  out_block_y,
  output logic [3:0]  out_block_size,
  output logic [15:0] out_block_color,
  output logic        out_last_block
);

  cfg_t cfg_r;
  logic push_valid, push_ready;
  job_t push_job;
  logic pop_valid, pop_ready;
  job_t pop_job;

  // configuration registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.fg_color   <= 16'hFFFF;
      cfg_r.bg_color   <= 16'h0000;
      cfg_r.text_size  <= 4'd1;
      cfg_r.display_on <= 1'b0;
    end else if (cfg_wr_en) begin
      unique case (cfg_index)
        REG_FG_COLOR:   cfg_r.fg_color   <= cfg_wdata;
        REG_BG_COLOR:   cfg_r.bg_color   <= cfg_wdata;
        REG_TEXT_SIZE:  cfg_r.text_size  <= cfg_wdata[3:0];
        REG_DISPLAY_ON: cfg_r.display_on <= cfg_wdata[0];
        default: ;
      endcase
    end
  end

  tcgr_front #(
    .SCREEN_WIDTH  (SCREEN_WIDTH),
    .SCREEN_HEIGHT (SCREEN_HEIGHT)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .cfg               (cfg_r),
    .in_valid          (in_valid),
    .in_ready          (in_ready),
    .in_opcode         (in_opcode),
    .in_char_code      (in_char_code),
    .in_string_start   (in_string_start),
    .in_cursor_x_value (in_cursor_x_value),
    .in_cursor_y_value (in_cursor_y_value),
    .push_valid        (push_valid),
    .push_ready        (push_ready),
    .push_job          (push_job)
  );

  tcgr_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  tcgr_back u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .cfg             (cfg_r),
    .pop_valid       (pop_valid),
    .pop_ready       (pop_ready),
    .pop_job         (pop_job),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_block_x     (out_block_x),
    .out_block_y     (out_block_y),
    .out_block_size  (out_block_size),
    .out_block_color (out_block_color),
    .out_last_block  (out_last_block)
  );

endmodule

[rtl/core/tcgr_front.sv]
module tcgr_front
  import tcgr_pkg::*;
#(
  parameter int SCREEN_WIDTH  = 240,
  parameter int SCREEN_HEIGHT = 285
) (
  input  logic       clk,
  input  logic       rst_n,
  input  cfg_t       cfg,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic       in_opcode,
  input  logic [7:0] in_char_code,
  input  logic       in_string_start,
  input  logic [9:0] in_cursor_x_value,
  input  logic [9:0] in_cursor_y_value,
  output logic       push_valid,
  input  logic       push_ready,
  output job_t       push_job
);

  logic [9:0] col_r, col_nxt;
  logic [9:0] row_r, row_nxt;
  logic       dropping_r, dropping_nxt;

  logic       accept;
  logic [3:0] size;
  logic [5:0] cw;
  logic [6:0] lh;
  logic [10:0] col_end;
  logic [10:0] row_adv;
  logic [9:0]  row_sat;
  logic        wrap;
  logic [9:0]  col1;
  logic [9:0]  row1;
  logic [10:0] row1_end;
  logic        bottom;
  logic        drop_eff;
  logic [6:0]  idx;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  // clamp the scale to 1..8
  always_comb begin
    if (cfg.text_size == 4'd0) begin
      size = 4'd1;
    end else if (cfg.text_size > 4'(SIZE_MAX)) begin
      size = 4'(SIZE_MAX);
    end else begin
      size = cfg.text_size;
    end
  end

  // cell width 6*size and line pitch 8*size
  assign cw = {size, 2'b00} + {1'b0, size, 1'b0};
  assign lh = {size, 3'b000};

  // right edge wrap and saturating line advance
  assign col_end = {1'b0, col_r} + 11'(cw);
  assign wrap    = col_end > 11'(SCREEN_WIDTH);
  assign row_adv = {1'b0, row_r} + 11'(lh);
  assign row_sat = row_adv[10] ? ROW_MAX : row_adv[9:0];
  assign col1    = wrap ? 10'd0 : col_r;
  assign row1    = wrap ? row_sat : row_r;

  // bottom edge check after any wrap
  assign row1_end = {1'b0, row1} + 11'(lh);
  assign bottom   = row1_end > 11'(SCREEN_HEIGHT);

  assign drop_eff = in_string_start ? 1'b0 : dropping_r;

  // unprintable codes draw as space
  assign idx = (in_char_code < GLYPH_FIRST || in_char_code > GLYPH_LAST) ?
               7'd0 : 7'(in_char_code - GLYPH_FIRST);

  // classify the incoming word
  always_comb begin
    col_nxt      = col_r;
    row_nxt      = row_r;
    dropping_nxt = dropping_r;
    push_valid   = 1'b0;
    if (accept) begin
      if (in_opcode == OP_SET_CURSOR) begin
        col_nxt = in_cursor_x_value;
        row_nxt = in_cursor_y_value;
      end else if (cfg.display_on) begin
        dropping_nxt = drop_eff;
        if (!drop_eff) begin
          if (in_char_code == CH_NEWLINE) begin
            col_nxt = 10'd0;
            row_nxt = row_sat;
          end else if (in_char_code != CH_RETURN) begin
            col_nxt = col1;
            row_nxt = row1;
            if (bottom) begin
              dropping_nxt = 1'b1;
            end else begin
              push_valid = 1'b1;
              col_nxt    = 10'({1'b0, col1} + 11'(cw));
            end
          end
        end
      end
    end
  end

  assign push_job.x0        = col1;
  assign push_job.y0        = row1;
  assign push_job.size      = size;
  assign push_job.glyph_idx = idx;

  // cursor state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r      <= '0;
      row_r      <= '0;
      dropping_r <= 1'b0;
    end else begin
      col_r      <= col_nxt;
      row_r      <= row_nxt;
      dropping_r <= dropping_nxt;
    end
  end

  // a pushed character lies fully inside the screen height
  a_push_in_screen: assert property (@(posedge clk) disable iff (!rst_n)
    push_valid |-> (row1_end <= 11'(SCREEN_HEIGHT)))
    else $error("front pushed a character below the bottom edge");

  // a rising drop flag comes from a character that overflowed the bottom edge
  a_drop_source: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(dropping_r) |-> $past(accept && in_opcode == OP_PUT_CHAR && bottom))
    else $error("drop flag set without a bottom overflow");

endmodule

[rtl/core/tcgr_queue.sv]
module tcgr_queue
  import tcgr_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  input  logic push_valid,
  output logic push_ready,
  input  job_t push_job,
  output logic pop_valid,
  input  logic pop_ready,
  output job_t pop_job
);

  localparam int PTR_W = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
  localparam int CNT_W = $clog2(QDEPTH + 1);

  job_t             slot_r [QDEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] count_r;
  logic             do_push, do_pop;

  assign push_ready = count_r != CNT_W'(QDEPTH);
  assign pop_valid  = count_r != '0;
  assign pop_job    = slot_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  // storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_job;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
      end
      count_r <= count_r + CNT_W'(do_push) - CNT_W'(do_pop);
    end
  end

  // fill count stays within depth
  a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CNT_W'(QDEPTH))
    else $error("queue count beyond depth");

endmodule

[rtl/core/tcgr_back.sv]
module tcgr_back
  import tcgr_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  cfg_t        cfg,
  input  logic        pop_valid,
  output logic        pop_ready,
  input  job_t        pop_job,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [7:0]  out_block_x,
  output logic [8:0]  out_block_y,
  output logic [3:0]  out_block_size,
  output logic [15:0] out_block_color,
  output logic        out_last_block
);

  logic        busy_r;
  job_t        job_r;
  logic [47:0] glyph_r;
  logic [2:0]  col_r, row_r;
  logic [5:0]  xoff_r, yoff_r;

  logic        out_valid_r;
  logic [7:0]  bx_r;
  logic [8:0]  by_r;
  logic [3:0]  bsize_r;
  logic [15:0] bcolor_r;
  logic        blast_r;

  logic        advance;
  logic        last_step;
  logic        load;

  // one block per cycle while the output register can take it
  assign advance   = busy_r && (!out_valid_r || out_ready);
  assign last_step = (col_r == LAST_COL) && (row_r == LAST_ROW);
  assign pop_ready = !busy_r || (advance && last_step);
  assign load      = pop_valid && pop_ready;

  // walk columns, and rows within a column
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
    end else if (load) begin
      busy_r <= 1'b1;
    end else if (advance && last_step) begin
      busy_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      job_r   <= pop_job;
      glyph_r <= glyph_rom(pop_job.glyph_idx);
      col_r   <= '0;
      row_r   <= '0;
      xoff_r  <= '0;
      yoff_r  <= '0;
    end else if (advance) begin
      if (row_r == LAST_ROW) begin
        row_r  <= '0;
        yoff_r <= '0;
        col_r  <= col_r + 3'd1;
        xoff_r <= xoff_r + 6'(job_r.size);
      end else begin
        row_r  <= row_r + 3'd1;
        yoff_r <= yoff_r + 6'(job_r.size);
      end
    end
  end

  // output word register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      bx_r     <= job_r.x0[7:0] + {2'b00, xoff_r};
      by_r     <= job_r.y0[8:0] + {3'b000, yoff_r};
      bsize_r  <= job_r.size;
      bcolor_r <= glyph_r[{col_r, row_r}] ? cfg.fg_color : cfg.bg_color;
      blast_r  <= last_step;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_block_x     = bx_r;
  assign out_block_y     = by_r;
  assign out_block_size  = bsize_r;
  assign out_block_color = bcolor_r;
  assign out_last_block  = blast_r;

  // the sequencer only goes idle right after issuing the final block
  a_idle_after_last: assert property (@(posedge clk) disable iff (!rst_n)
    $fell(busy_r) |-> $past(advance && last_step))
    else $error("sequencer dropped a character early");

  // no new character is taken mid glyph
  a_load_on_boundary: assert property (@(posedge clk) disable iff (!rst_n)
    (load && busy_r) |-> (advance && last_step))
    else $error("character loaded while another is in flight");

  // block size is the clamped scale
  a_size_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> (bsize_r != 4'd0 && bsize_r <= 4'(SIZE_MAX)))
    else $error("block size out of range");

endmodule

[tb/tb_text_cursor_glyph_renderer_unit.sv]
module tb_text_cursor_glyph_renderer_unit
  import tcgr_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int SCREEN_W      = 240;
  localparam int SCREEN_H      = 285;
  localparam int SETTLE_CYCLES = 12;
  localparam int STALL_LIMIT   = 2000;
  localparam int PHASE_WORDS   = 29;

  // text sizes for the first idling mode, clamped values included
  localparam logic [3:0] SIZE_SWEEP [4] = '{4'd1, 4'd8, 4'd0, 4'd15};

  // 5x7 font, one entry per printable code, column 0 in the top byte, bit 0 is the top row
  localparam logic [39:0] FONT_5X7 [95] = '{
    40'h00_00_00_00_00, 40'h00_00_5F_00_00, 40'h00_07_00_07_00, 40'h14_7F_14_7F_14,
    40'h24_2A_7F_2A_12, 40'h23_13_08_64_62, 40'h36_49_55_22_50, 40'h00_05_03_00_00,
    40'h00_1C_22_41_00, 40'h00_41_22_1C_00, 40'h14_08_3E_08_14, 40'h08_08_3E_08_08,
    40'h00_00_A0_60_00, 40'h08_08_08_08_08, 40'h00_60_60_00_00, 40'h20_10_08_04_02,
    40'h3E_51_49_45_3E, 40'h00_42_7F_40_00, 40'h42_61_51_49_46, 40'h21_41_45_4B_31,
    40'h18_14_12_7F_10, 40'h27_45_45_45_39, 40'h3C_4A_49_49_30, 40'h01_71_09_05_03,
    40'h36_49_49_49_36, 40'h06_49_49_29_1E, 40'h00_36_36_00_00, 40'h00_56_36_00_00,
    40'h08_14_22_41_00, 40'h14_14_14_14_14, 40'h00_41_22_14_08, 40'h02_01_51_09_06,
    40'h32_49_59_51_3E, 40'h7C_12_11_12_7C, 40'h7F_49_49_49_36, 40'h3E_41_41_41_22,
    40'h7F_41_41_22_1C, 40'h7F_49_49_49_41, 40'h7F_09_09_09_01, 40'h3E_41_49_49_7A,
    40'h7F_08_08_08_7F, 40'h00_41_7F_41_00, 40'h20_40_41_3F_01, 40'h7F_08_14_22_41,
    40'h7F_40_40_40_40, 40'h7F_02_0C_02_7F, 40'h7F_04_08_10_7F, 40'h3E_41_41_41_3E,
    40'h7F_09_09_09_06, 40'h3E_41_51_21_5E, 40'h7F_09_19_29_46, 40'h46_49_49_49_31,
    40'h01_01_7F_01_01, 40'h3F_40_40_40_3F, 40'h1F_20_40_20_1F, 40'h3F_40_38_40_3F,
    40'h63_14_08_14_63, 40'h07_08_70_08_07, 40'h61_51_49_45_43, 40'h00_7F_41_41_00,
    40'h55_2A_55_2A_55, 40'h00_41_41_7F_00, 40'h04_02_01_02_04, 40'h40_40_40_40_40,
    40'h00_01_02_04_00, 40'h20_54_54_54_78, 40'h7F_48_44_44_38, 40'h38_44_44_44_20,
    40'h38_44_44_48_7F, 40'h38_54_54_54_18, 40'h08_7E_09_01_02, 40'h0C_52_52_52_3E,
    40'h7F_08_04_04_78, 40'h00_44_7D_40_00, 40'h20_40_44_3D_00, 40'h00_7F_10_28_44,
    40'h00_41_7F_40_00, 40'h7C_04_18_04_78, 40'h7C_08_04_04_78, 40'h38_44_44_44_38,
    40'h7C_14_14_14_08, 40'h08_14_14_18_7C, 40'h7C_08_04_04_08, 40'h48_54_54_54_20,
    40'h04_3F_44_40_20, 40'h3C_40_40_20_7C, 40'h1C_20_40_20_1C, 40'h3C_40_30_40_3C,
    40'h44_28_10_28_44, 40'h0C_50_50_50_3C, 40'h44_64_54_4C_44, 40'h08_36_41_00_00,
    40'h00_00_7F_00_00, 40'h00_41_36_08_00, 40'h10_08_08_10_08
  };

  typedef struct packed {
    logic [7:0]  x;
    logic [8:0]  y;
    logic [3:0]  size;
    logic [15:0] color;
    logic        last;
  } glyph_block_t;

  logic        clk;
  logic        rst_n;
  logic        cfg_wr_en;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_wdata;
  logic        in_valid;
  logic        in_ready;
  logic        in_opcode;
  logic [7:0]  in_char_code;
  logic        in_string_start;
  logic [9:0]  in_cursor_x_value;
  logic [9:0]  in_cursor_y_value;
  logic        out_valid;
  logic        out_ready;
  logic [7:0]  out_block_x;
  logic [8:0]  out_block_y;
  logic [3:0]  out_block_size;
  logic [15:0] out_block_color;
  logic        out_last_block;

  // shadow registers and text state of the expected behavior
  logic [15:0] sh_fg_color = 16'hFFFF;
  logic [15:0] sh_bg_color = 16'h0000;
  logic [3:0]  sh_text_size = 4'd1;
  logic        sh_display_on = 1'b0;
  logic [9:0]  cur_col = '0;
  logic [9:0]  cur_row = '0;
  logic        drop_rest = 1'b0;

  glyph_block_t pending_blocks[$];
  glyph_block_t seen_blk;
  glyph_block_t want_blk;
  int unsigned  in_idle_pct = 37;
  int unsigned  out_idle_pct = 56;
  int unsigned  idle_cycles = 0;
  int           mismatches = 0;

  text_cursor_glyph_renderer_unit #(
    .SCREEN_WIDTH (SCREEN_W),
    .SCREEN_HEIGHT(SCREEN_H)
  ) dut (
    .clk              (clk),
    .rst_n            (rst_n),
    .cfg_wr_en        (cfg_wr_en),
    .cfg_index        (cfg_index),
    .cfg_wdata        (cfg_wdata),
    .in_valid         (in_valid),
    .in_ready         (in_ready),
    .in_opcode        (in_opcode),
    .in_char_code     (in_char_code),
    .in_string_start  (in_string_start),
    .in_cursor_x_value(in_cursor_x_value),
    .in_cursor_y_value(in_cursor_y_value),
    .out_valid        (out_valid),
    .out_ready        (out_ready),
    .out_block_x      (out_block_x),
    .out_block_y      (out_block_y),
    .out_block_size   (out_block_size),
    .out_block_color  (out_block_color),
    .out_last_block   (out_last_block)
  );

  // 12 ns clock
  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  // line feed with saturation of the row
  function automatic logic [9:0] next_line_row(logic [9:0] row, int pitch);
    return (int'(row) + pitch > int'(ROW_MAX)) ? ROW_MAX : 10'(int'(row) + pitch);
  endfunction

  // update the text state for one word and queue the blocks it draws
  function automatic void render_word(op_t op, logic [7:0] ch, logic start,
                                      logic [9:0] x, logic [9:0] y);
    int s;
    int glyph;
    logic [7:0] font_col;
    glyph_block_t blk;
    if (op == OP_SET_CURSOR) begin
      cur_col = x;
      cur_row = y;
      return;
    end
    if (!sh_display_on) return;
    if (start) drop_rest = 1'b0;
    if (drop_rest) return;
    s = (sh_text_size == 4'd0) ? 1 :
        (int'(sh_text_size) > SIZE_MAX) ? SIZE_MAX : int'(sh_text_size);
    if (ch == CH_NEWLINE) begin
      cur_col = '0;
      cur_row = next_line_row(cur_row, 8 * s);
      return;
    end
    if (ch == CH_RETURN) return;
    // wrap before the right edge, drop below the bottom
    if (int'(cur_col) + GLYPH_COLS * s > SCREEN_W) begin
      cur_col = '0;
      cur_row = next_line_row(cur_row, 8 * s);
    end
    if (int'(cur_row) + 8 * s > SCREEN_H) begin
      drop_rest = 1'b1;
      return;
    end
    glyph = (ch < GLYPH_FIRST || ch > GLYPH_LAST) ? 0 : int'(ch - GLYPH_FIRST);
    // five font columns then the blank spacing column, top to bottom
    for (int col = 0; col < GLYPH_COLS; col++) begin
      font_col = (col < GLYPH_COLS - 1) ? FONT_5X7[glyph][39 - 8 * col -: 8] : 8'h00;
      for (int row = 0; row < GLYPH_ROWS; row++) begin
        blk.x     = 8'(int'(cur_col) + col * s);
        blk.y     = 9'(int'(cur_row) + row * s);
        blk.size  = 4'(s);
        blk.color = font_col[row] ? sh_fg_color : sh_bg_color;
        blk.last  = (col == GLYPH_COLS - 1) && (row == GLYPH_ROWS - 1);
        pending_blocks.push_back(blk);
      end
    end
    cur_col = 10'(int'(cur_col) + GLYPH_COLS * s);
  endfunction

  function automatic logic [15:0] pick_color();
    case ($urandom_range(3))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      default: return 16'($urandom);
    endcase
  endfunction

  // one register write, the enable drops on the following edge
  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    cfg_wr_en <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= val;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    case (idx)
      REG_FG_COLOR:   sh_fg_color   = val;
      REG_BG_COLOR:   sh_bg_color   = val;
      REG_TEXT_SIZE:  sh_text_size  = val[3:0];
      REG_DISPLAY_ON: sh_display_on = val[0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // send one input word; valid stays high after acceptance until the next call
  task automatic send_word(input op_t op, input logic [7:0] ch, input logic start,
                           input logic [9:0] x, input logic [9:0] y);
    int unsigned gap;
    gap = 0;
    while ($urandom_range(99) < in_idle_pct) gap++;
    if (gap != 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid          <= 1'b1;
    in_opcode         <= op;
    in_char_code      <= ch;
    in_string_start   <= start;
    in_cursor_x_value <= x;
    in_cursor_y_value <= y;
    do @(posedge clk); while (!in_ready);
    render_word(op, ch, start, x, y);
  endtask

  task automatic put_char(input logic [7:0] ch, input logic start);
    send_word(OP_PUT_CHAR, ch, start, 10'($urandom), 10'($urandom));
  endtask

  task automatic set_cursor(input logic [9:0] x, input logic [9:0] y);
    send_word(OP_SET_CURSOR, 8'($urandom), 1'($urandom), x, y);
  endtask

  // stop sending and let every expected block and queued word drain
  task automatic settle();
    in_valid <= 1'b0;
    while (pending_blocks.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // glyph edges, unknown codes, newline and carriage return at size 1
  task automatic test_basic_glyphs();
    write_reg(REG_FG_COLOR, 16'hF800);
    write_reg(REG_BG_COLOR, 16'h001F);
    write_reg(REG_TEXT_SIZE, 16'd1);
    write_reg(REG_DISPLAY_ON, 16'd1);
    set_cursor(10'd0, 10'd0);
    put_char(8'd65, 1'b1);
    put_char(GLYPH_FIRST, 1'b0);
    put_char(GLYPH_LAST, 1'b0);
    put_char(8'd0, 1'b0);
    put_char(8'd255, 1'b0);
    put_char(8'd44, 1'b0);
    put_char(CH_NEWLINE, 1'b0);
    put_char(CH_RETURN, 1'b0);
    // exactly at the right edge, no wrap
    set_cursor(10'd234, 10'd8);
    put_char(8'd64, 1'b0);
    settle();
  endtask

  // wrap, bottom-edge drop, drop flag handling and row saturation at size 8
  task automatic test_wrap_and_drop();
    write_reg(REG_TEXT_SIZE, 16'd8);
    set_cursor(10'd200, 10'd0);
    put_char(8'd87, 1'b1);
    set_cursor(10'd192, 10'd221);
    put_char(8'd35, 1'b1);
    put_char(8'd36, 1'b0);
    put_char(CH_NEWLINE, 1'b0);
    put_char(8'd37, 1'b1);
    set_cursor(10'd0, 10'd0);
    put_char(8'd38, 1'b0);
    put_char(8'd39, 1'b1);
    set_cursor(10'd1023, 10'd1023);
    put_char(CH_NEWLINE, 1'b1);
    put_char(8'd40, 1'b0);
    settle();
  endtask

  // display off ignores characters and string start, set cursor still lands
  task automatic test_display_off();
    write_reg(REG_DISPLAY_ON, 16'd0);
    put_char(8'd66, 1'b1);
    set_cursor(10'd100, 10'd50);
    settle();
    write_reg(REG_DISPLAY_ON, 16'd1);
    put_char(8'd67, 1'b0);
    put_char(8'd68, 1'b1);
    settle();
  endtask

  // random strings under three idling modes and several register settings
  task automatic test_random_text();
    int unsigned counted;
    int unsigned len;
    int unsigned r;
    logic [7:0]  ch;
    logic        start;
    for (int mode = 0; mode < 3; mode++) begin
      in_idle_pct  = (mode == 0) ? 37 : (mode == 1) ? 56 : 0;
      out_idle_pct = (mode == 0) ? 56 : (mode == 1) ? 37 : 0;
      for (int phase = 0; phase < 4; phase++) begin
        settle();
        write_reg(REG_FG_COLOR, pick_color());
        write_reg(REG_BG_COLOR, pick_color());
        if (mode == 0) write_reg(REG_TEXT_SIZE, 16'(SIZE_SWEEP[phase]));
        else if ($urandom_range(3) == 0) write_reg(REG_TEXT_SIZE, 16'($urandom_range(15)));
        else write_reg(REG_TEXT_SIZE, 16'($urandom_range(1, 3)));
        write_reg(REG_DISPLAY_ON, 16'($urandom_range(7) != 0));
        counted = 0;
        while (counted < PHASE_WORDS) begin
          // most strings start from a fresh cursor on screen, a few anywhere
          r = $urandom_range(99);
          if (r < 75) begin
            set_cursor(10'($urandom_range(SCREEN_W - 1)), 10'($urandom_range(SCREEN_H - 1)));
            counted++;
          end else if (r < 85) begin
            set_cursor(10'($urandom), 10'($urandom));
            counted++;
          end
          len = $urandom_range(1, 10);
          for (int i = 0; i < len; i++) begin
            r = $urandom_range(99);
            if (r < 70) ch = 8'($urandom_range(GLYPH_FIRST, GLYPH_LAST));
            else if (r < 78) ch = CH_NEWLINE;
            else if (r < 83) ch = CH_RETURN;
            else ch = 8'($urandom);
            start = (i == 0) ? ($urandom_range(9) != 0) : ($urandom_range(19) == 0);
            put_char(ch, start);
            counted++;
          end
        end
      end
    end
    settle();
  endtask

  // receiver stalls
  always @(posedge clk) begin
    out_ready <= ($urandom_range(99) >= out_idle_pct);
  end

  // compare each output word with the oldest expected block
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      seen_blk = '{x: out_block_x, y: out_block_y, size: out_block_size,
                   color: out_block_color, last: out_last_block};
      if (pending_blocks.size() == 0) begin
        mismatches++;
        if (mismatches <= 10)
          $display("unexpected block: x=%0d y=%0d size=%0d color=%h last=%b",
                   seen_blk.x, seen_blk.y, seen_blk.size, seen_blk.color, seen_blk.last);
      end else begin
        want_blk = pending_blocks.pop_front();
        if (seen_blk.x !== want_blk.x || seen_blk.y !== want_blk.y ||
            seen_blk.size !== want_blk.size || seen_blk.color !== want_blk.color ||
            seen_blk.last !== want_blk.last) begin
          mismatches++;
          if (mismatches <= 10)
            $display("block mismatch at %0t: exp x=%0d y=%0d size=%0d color=%h last=%b, %s",
                     $realtime, want_blk.x, want_blk.y, want_blk.size, want_blk.color,
                     want_blk.last,
                     $sformatf("got x=%0d y=%0d size=%0d color=%h last=%b",
                               seen_blk.x, seen_blk.y, seen_blk.size, seen_blk.color,
                               seen_blk.last));
        end
      end
    end
  end

  // watchdog on cycles without any accepted word
  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready)) begin
      idle_cycles <= 0;
    end else if (idle_cycles >= STALL_LIMIT) begin
      $display("FAILED: results differ");
      $finish;
    end else begin
      idle_cycles <= idle_cycles + 1;
    end
  end

  initial begin
    rst_n             = 1'b0;
    cfg_wr_en         = 1'b0;
    cfg_index         = REG_FG_COLOR;
    cfg_wdata         = '0;
    in_valid          = 1'b0;
    in_opcode         = OP_PUT_CHAR;
    in_char_code      = '0;
    in_string_start   = 1'b0;
    in_cursor_x_value = '0;
    in_cursor_y_value = '0;
    out_ready         = 1'b0;
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;

    test_basic_glyphs();
    test_wrap_and_drop();
    test_display_off();
    test_random_text();

    if (mismatches == 0) begin
      $display("PASSED: all results match");
    end else begin
      $display("FAILED: results differ");
    end
    $finish;
  end

endmodule

[sim.f]
rtl/core/tcgr_pkg.sv
rtl/core/tcgr_front.sv
rtl/core/tcgr_queue.sv
rtl/core/tcgr_back.sv
rtl/core/text_cursor_glyph_renderer_unit.sv
tb/tb_text_cursor_glyph_renderer_unit.sv
